@@ design/nfps_pkg.sv @@
package nfps_pkg;

	// Default array geometry.
	localparam int NFPS_BANKS      = 4;
	localparam int NFPS_BLOCKS     = 16;
	localparam int NFPS_PAGES      = 16;
	localparam int NFPS_DATA_WORDS = 4;

	// Fixed field widths.
	localparam int WORD_W  = 64;
	localparam int SPARE_W = 32;
	localparam int PAGE_W  = WORD_W + SPARE_W;

	// Configuration port widths.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Command codes.
	localparam logic [1:0] CMD_STAGE   = 2'd0;
	localparam logic [1:0] CMD_PROGRAM = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_ERASE   = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_OVERWRITE = 3'd2;
	localparam logic [2:0] ST_POSITION  = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_BANK_COUNT  = 2'd0;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
	localparam logic [1:0] REG_PAGE_COUNT  = 2'd2;

	// Register reset values.
	localparam logic [2:0] RST_BANK_COUNT  = 3'd4;
	localparam logic [4:0] RST_BLOCK_COUNT = 5'd16;
	localparam logic [4:0] RST_PAGE_COUNT  = 5'd16;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [1:0]         bank;
		logic [3:0]         block;
		logic [3:0]         page;
		logic [1:0]         word_index;
		logic [WORD_W-1:0]  data_word;
		logic [SPARE_W-1:0] spare_in;
	} nfps_req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [WORD_W-1:0]  read_word;
		logic [SPARE_W-1:0] spare_out;
		logic               last;
	} nfps_rsp_t;

	typedef struct packed {
		logic [2:0] bank_count;
		logic [4:0] block_count;
		logic [4:0] page_count;
	} nfps_cfg_t;

	// A count above the geometry acts as the geometry.
	function automatic logic [7:0] cap_count(input logic [7:0] count, input logic [7:0] cap);
		return (count < cap) ? count : cap;
	endfunction

endpackage

@@ design/nfps_ram.sv @@
module nfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds between read enables.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/nfps_regs.sv @@
module nfps_regs
	import nfps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output nfps_cfg_t         cfg
);

	nfps_cfg_t  cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bank_count  <= RST_BANK_COUNT;
			cfg_q.block_count <= RST_BLOCK_COUNT;
			cfg_q.page_count  <= RST_PAGE_COUNT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BANK_COUNT:  cfg_q.bank_count  <= pwdata[2:0];
				REG_BLOCK_COUNT: cfg_q.block_count <= pwdata[4:0];
				REG_PAGE_COUNT:  cfg_q.page_count  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_BANK_COUNT:  prdata[2:0] = cfg_q.bank_count;
			REG_BLOCK_COUNT: prdata[4:0] = cfg_q.block_count;
			REG_PAGE_COUNT:  prdata[4:0] = cfg_q.page_count;
			default:         prdata      = '0;
		endcase
	end

endmodule

@@ design/nfps_seq.sv @@
module nfps_seq
	import nfps_pkg::*;
#(
	parameter int BANKS      = NFPS_BANKS,
	parameter int BLOCKS     = NFPS_BLOCKS,
	parameter int PAGES      = NFPS_PAGES,
	parameter int DATA_WORDS = NFPS_DATA_WORDS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  nfps_cfg_t cfg,
	input  logic      req_valid,
	input  nfps_req_t req,
	output logic      req_stall,
	input  logic      out_free,
	output logic      emit,
	output nfps_rsp_t emit_rsp
);

	localparam int NBLK   = BANKS * BLOCKS;
	localparam int BI_W   = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int NPW    = NBLK * PAGES * DATA_WORDS;
	localparam int PW_W   = (NPW > 1) ? $clog2(NPW) : 1;
	localparam int WP_W   = $clog2(PAGES + 1);
	localparam int SW_W   = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
	localparam logic [SW_W-1:0] W_LAST   = SW_W'(DATA_WORDS - 1);
	localparam logic [BI_W-1:0] CLR_LAST = BI_W'(NBLK - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_PROG,
		S_READ
	} seq_state_t;

	seq_state_t state_q;
	logic [BI_W-1:0] clr_q;
	logic [SW_W-1:0] w_q;

	// Command held for the duration of its work.
	logic [1:0]         cmd_q;
	logic [1:0]         bank_q;
	logic [3:0]         block_q;
	logic [3:0]         page_q;
	logic [1:0]         widx_q;
	logic [WORD_W-1:0]  data_q;
	logic [SPARE_W-1:0] spare_q;
	logic [BI_W-1:0]    bi_q;

	logic [WORD_W-1:0] staged_q [DATA_WORDS];

	logic            accept;
	logic [BI_W-1:0] req_bi;
	logic            act;

	logic            wp_we;
	logic [BI_W-1:0] wp_waddr;
	logic [WP_W-1:0] wp_wdata;
	logic [WP_W-1:0] wp_rdata;

	logic              pg_we;
	logic [PW_W-1:0]   pg_waddr;
	logic [PAGE_W-1:0] pg_wdata;
	logic              pg_re;
	logic [PW_W-1:0]   pg_raddr;
	logic [PAGE_W-1:0] pg_rdata;
	logic [PW_W-1:0]   page_base;
	logic [SW_W-1:0]   rd_w;

	logic [7:0] bank_lim;
	logic [7:0] block_lim;
	logic [7:0] page_lim;
	logic       bad_blk;
	logic       bad_page;
	logic [7:0] wp8;
	logic [7:0] pg8;

	logic [2:0]      chk_status;
	logic            chk_prog;
	logic            chk_read;
	logic            chk_wp_we;
	logic [WP_W-1:0] chk_wp_val;
	logic            chk_stage_we;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_bi    = BI_W'(BI_W'(req.bank) * BI_W'(BLOCKS) + BI_W'(req.block));
	assign act       = (state_q == S_CHECK) && out_free;

	// Address checks against the configured counts.
	assign bank_lim  = cap_count(8'(cfg.bank_count), 8'(BANKS));
	assign block_lim = cap_count(8'(cfg.block_count), 8'(BLOCKS));
	assign page_lim  = cap_count(8'(cfg.page_count), 8'(PAGES));
	assign bad_blk   = (8'(bank_q) >= bank_lim) || (8'(block_q) >= block_lim);
	assign bad_page  = (8'(page_q) >= page_lim);
	assign wp8       = 8'(wp_rdata);
	assign pg8       = 8'(page_q);

	always_comb begin
		chk_status   = ST_OK;
		chk_prog     = 1'b0;
		chk_read     = 1'b0;
		chk_wp_we    = 1'b0;
		chk_wp_val   = '0;
		chk_stage_we = 1'b0;
		if (cmd_q == CMD_STAGE) begin
			if (4'(widx_q) < 4'(DATA_WORDS)) begin
				chk_stage_we = 1'b1;
			end else begin
				chk_status = ST_INVALID;
			end
		end else if (bad_blk || (cmd_q != CMD_ERASE && bad_page)) begin
			chk_status = ST_INVALID;
		end else begin
			case (cmd_q)
				CMD_ERASE: begin
					if (wp8 == 8'd0) begin
						chk_status = ST_EMPTY;
					end else begin
						chk_wp_we = 1'b1;
					end
				end
				CMD_PROGRAM: begin
					if (pg8 < wp8) begin
						chk_status = ST_OVERWRITE;
					end else if (pg8 > wp8) begin
						chk_status = ST_POSITION;
					end else begin
						chk_wp_we  = 1'b1;
						chk_wp_val = WP_W'(wp_rdata + 1'b1);
						chk_prog   = 1'b1;
					end
				end
				CMD_READ: begin
					if (pg8 >= wp8) begin
						chk_status = ST_EMPTY;
					end else begin
						chk_read = 1'b1;
					end
				end
				default: chk_status = ST_OK;
			endcase
		end
	end

	// Write pointer memory: cleared by the sweep after reset, read on accept.
	assign wp_we    = (state_q == S_CLEAR) || (act && chk_wp_we);
	assign wp_waddr = (state_q == S_CLEAR) ? clr_q : bi_q;
	assign wp_wdata = (state_q == S_CLEAR) ? '0 : chk_wp_val;

	nfps_ram #(
		.WIDTH(WP_W),
		.DEPTH(NBLK)
	) u_wp_ram (
		.clk  (clk),
		.we   (wp_we),
		.waddr(wp_waddr),
		.wdata(wp_wdata),
		.re   (accept),
		.raddr(req_bi),
		.rdata(wp_rdata)
	);

	// Page memory: one entry per data word, each carrying the page spare too.
	assign page_base = PW_W'(PW_W'(bi_q) * PW_W'(PAGES * DATA_WORDS)
		+ PW_W'(page_q) * PW_W'(DATA_WORDS));
	assign rd_w      = (state_q == S_READ) ? SW_W'(w_q + 1'b1) : '0;
	assign pg_we     = (state_q == S_PROG);
	assign pg_waddr  = PW_W'(page_base + PW_W'(w_q));
	assign pg_wdata  = {spare_q, staged_q[w_q]};
	assign pg_re     = (act && chk_read)
		|| ((state_q == S_READ) && out_free && (w_q != W_LAST));
	assign pg_raddr  = PW_W'(page_base + PW_W'(rd_w));

	nfps_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(NPW)
	) u_page_ram (
		.clk  (clk),
		.we   (pg_we),
		.waddr(pg_waddr),
		.wdata(pg_wdata),
		.re   (pg_re),
		.raddr(pg_raddr),
		.rdata(pg_rdata)
	);

	// Result towards the output register.
	always_comb begin
		emit = 1'b0;
		emit_rsp.status    = chk_status;
		emit_rsp.read_word = '0;
		emit_rsp.spare_out = '0;
		emit_rsp.last      = 1'b1;
		if (state_q == S_READ) begin
			emit               = out_free;
			emit_rsp.status    = ST_OK;
			emit_rsp.read_word = pg_rdata[WORD_W-1:0];
			emit_rsp.spare_out = pg_rdata[PAGE_W-1:WORD_W];
			emit_rsp.last      = (w_q == W_LAST);
		end else if (state_q == S_CHECK) begin
			emit = out_free && !chk_read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			w_q     <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= BI_W'(clr_q + 1'b1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (out_free) begin
						w_q <= '0;
						if (chk_prog) begin
							state_q <= S_PROG;
						end else if (chk_read) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PROG: begin
					w_q <= SW_W'(w_q + 1'b1);
					if (w_q == W_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						if (w_q == W_LAST) begin
							state_q <= S_IDLE;
						end else begin
							w_q <= SW_W'(w_q + 1'b1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			bank_q  <= req.bank;
			block_q <= req.block;
			page_q  <= req.page;
			widx_q  <= req.word_index;
			data_q  <= req.data_word;
			spare_q <= req.spare_in;
			bi_q    <= req_bi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DATA_WORDS; i++) begin
				staged_q[i] <= '0;
			end
		end else if (act && chk_stage_we) begin
			staged_q[SW_W'(widx_q)] <= data_q;
		end
	end

endmodule

@@ design/nand_flash_sequential_page_store_core.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  nfps_req_t: command, address, data word, spare
// rsp       out        rsp_valid/rsp_stall  nfps_rsp_t: status, read word, spare, last
// apb       in         psel/penable/pready  bank, block and page count registers
//
// A command is taken, then its block's write pointer is read from the pointer memory
// and checked in the following cycle. A successful program then writes its DATA_WORDS
// words to the page memory, and a successful read streams DATA_WORDS words at one per
// cycle from the page memory's read port while the output is not stalled.
// After reset the pointer memory is swept to zero, one block a cycle; req_stall stays
// high meanwhile. A stalled output holds the sequencer in its check or read state;
// the output register lets a new command be taken while a result awaits transfer.
module nand_flash_sequential_page_store_core
	import nfps_pkg::*;
#(
	parameter int BANKS      = NFPS_BANKS,
	parameter int BLOCKS     = NFPS_BLOCKS,
	parameter int PAGES      = NFPS_PAGES,
	parameter int DATA_WORDS = NFPS_DATA_WORDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  nfps_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output nfps_rsp_t         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	nfps_cfg_t cfg;
	logic      out_free;
	logic      emit;
	nfps_rsp_t emit_rsp;
	logic      rsp_valid_q;
	nfps_rsp_t rsp_q;

	// Configuration registers; the user must write them only while no command is in flight (not enforced here).
	nfps_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Sequencer with the pointer and page memories.
	nfps_seq #(
		.BANKS     (BANKS),
		.BLOCKS    (BLOCKS),
		.PAGES     (PAGES),
		.DATA_WORDS(DATA_WORDS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.req_valid(req_valid),
		.req      (req),
		.req_stall(req_stall),
		.out_free (out_free),
		.emit     (emit),
		.emit_rsp (emit_rsp)
	);

	// The output register can load when it is empty or its transfer completes now.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_rsp;
		end
	end

endmodule
